// File: design/tcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcf_pkg - shared types and codes for the two-class oldest-first FIFO
// Word layouts for the command and result channels, command and status
// codes, and the per-class control and flag groups.
// ----------------------------------------------------------------------------
package tcf_pkg;

  localparam int TAG_W         = 8;
  localparam int DEPTH_DEF     = 16;
  localparam int STAMP_DEF     = 16;

  // command codes
  localparam logic [1:0] CMD_ENQ        = 2'd0;
  localparam logic [1:0] CMD_DEQ_NAMED  = 2'd1;
  localparam logic [1:0] CMD_DEQ_OLDEST = 2'd2;
  localparam logic [1:0] CMD_NOP        = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // class codes
  localparam logic CLS_FIRST  = 1'b0;
  localparam logic CLS_SECOND = 1'b1;

  typedef struct packed {
    logic [1:0]       command;
    logic             item_class;
    logic [TAG_W-1:0] item_tag;
  } in_word_t;

  typedef struct packed {
    logic [TAG_W-1:0] out_tag;
    logic             served_class;
    logic [1:0]       status;
  } out_word_t;

  // per-class control from the scheduler
  typedef struct packed {
    logic push;
    logic pop;
  } ring_ctl_t;

  // per-class occupancy flags back to the scheduler
  typedef struct packed {
    logic empty;
    logic full;
  } ring_flags_t;

endpackage

// File: design/two_class_fifo_oldest_first.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_class_fifo_oldest_first - two-class FIFO with oldest-first dequeue
// Two circular FIFOs with a shared arrival stamp; enqueue, named dequeue
// and oldest-of-either dequeue.
// ----------------------------------------------------------------------------
// One command is taken in every cycle: busy never rises. Each command gives
// exactly one result word, shown on out_data with out_strobe high for one
// cycle. The command is first loaded into the command register, then the
// result register is loaded after decode and the head compare. The receiver
// cannot stall, so results must be captured on the strobe. Each class holds
// DEPTH-1 entries; the head entry of each class is read ahead from its
// memory port into a register, so decode and compare need no memory read.
// ----------------------------------------------------------------------------
module two_class_fifo_oldest_first #(
  parameter int DEPTH      = tcf_pkg::DEPTH_DEF,
  parameter int STAMP_BITS = tcf_pkg::STAMP_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  tcf_pkg::in_word_t  in_data,
  output logic               out_strobe,
  output tcf_pkg::out_word_t out_data
);
  import tcf_pkg::*;

  logic                  cmd_valid_r;
  in_word_t              cmd_r;
  logic                  strobe_r;
  out_word_t             result_r, result_nxt;
  logic [STAMP_BITS-1:0] arrival_r, arrival_nxt;
  logic                  bump_arrival;
  ring_ctl_t             ctl0, ctl1;
  ring_flags_t           flags0, flags1;
  logic [TAG_W-1:0]      tag0, tag1;
  logic [STAMP_BITS-1:0] stamp0, stamp1;

  assign busy = 1'b0;

  // hold the accepted command word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
    end else begin
      cmd_valid_r <= start;
    end
    cmd_r <= in_data;
  end

  tcf_ring #(.DEPTH(DEPTH), .STAMP_BITS(STAMP_BITS)) u_ring0 (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl0),
    .push_tag   (cmd_r.item_tag),
    .push_stamp (arrival_r),
    .flags      (flags0),
    .head_tag   (tag0),
    .head_stamp (stamp0)
  );

  tcf_ring #(.DEPTH(DEPTH), .STAMP_BITS(STAMP_BITS)) u_ring1 (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl1),
    .push_tag   (cmd_r.item_tag),
    .push_stamp (arrival_r),
    .flags      (flags1),
    .head_tag   (tag1),
    .head_stamp (stamp1)
  );

  tcf_sched #(.STAMP_BITS(STAMP_BITS)) u_sched (
    .cmd_valid    (cmd_valid_r),
    .cmd          (cmd_r),
    .arrival      (arrival_r),
    .flags0       (flags0),
    .flags1       (flags1),
    .tag0         (tag0),
    .tag1         (tag1),
    .stamp0       (stamp0),
    .stamp1       (stamp1),
    .ctl0         (ctl0),
    .ctl1         (ctl1),
    .bump_arrival (bump_arrival),
    .result       (result_nxt)
  );

  // advance the arrival counter on each stored word
  assign arrival_nxt = bump_arrival ? arrival_r + STAMP_BITS'(1) : arrival_r;

  // register the result word and its strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arrival_r <= '0;
      strobe_r  <= 1'b0;
    end else begin
      arrival_r <= arrival_nxt;
      strobe_r  <= cmd_valid_r;
    end
    result_r <= result_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_data   = result_r;

endmodule

// File: design/tcf_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcf_ring - one class's circular FIFO
// Entry memory with head and tail pointers. One slot always stays empty.
// The head entry is read ahead from the next head pointer, so it is held in
// a register for the following cycle; a write to that slot is forwarded.
// ----------------------------------------------------------------------------
module tcf_ring #(
  parameter int DEPTH      = tcf_pkg::DEPTH_DEF,
  parameter int STAMP_BITS = tcf_pkg::STAMP_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tcf_pkg::ring_ctl_t        ctl,
  input  logic [tcf_pkg::TAG_W-1:0] push_tag,
  input  logic [STAMP_BITS-1:0]     push_stamp,
  output tcf_pkg::ring_flags_t      flags,
  output logic [tcf_pkg::TAG_W-1:0] head_tag,
  output logic [STAMP_BITS-1:0]     head_stamp
);
  import tcf_pkg::*;

  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ENTRY_W = TAG_W + STAMP_BITS;
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_r;
  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [PTR_W-1:0]   tail_r, tail_nxt;
  logic [ENTRY_W-1:0] wr_entry;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == LAST) ? '0 : p + PTR_W'(1);
  endfunction

  assign wr_entry = {push_tag, push_stamp};

  // advance pointers
  assign head_nxt = ctl.pop  ? bump(head_r) : head_r;
  assign tail_nxt = ctl.push ? bump(tail_r) : tail_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  // write at tail, read ahead at next head with write forwarding
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail_r] <= wr_entry;
    end
    if (ctl.push && (tail_r == head_nxt)) begin
      rd_r <= wr_entry;
    end else begin
      rd_r <= mem[head_nxt];
    end
  end

  assign flags.empty = (head_r == tail_r);
  assign flags.full  = (bump(tail_r) == head_r);
  assign head_tag    = rd_r[ENTRY_W-1:STAMP_BITS];
  assign head_stamp  = rd_r[STAMP_BITS-1:0];

endmodule

// File: design/tcf_sched.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcf_sched - command decode and class selection
// Turns one registered command into push and pop controls for the two
// classes and forms the result word. Oldest-first compares ages taken
// against the arrival counter.
// ----------------------------------------------------------------------------
module tcf_sched #(
  parameter int STAMP_BITS = tcf_pkg::STAMP_DEF
) (
  input  logic                      cmd_valid,
  input  tcf_pkg::in_word_t         cmd,
  input  logic [STAMP_BITS-1:0]     arrival,
  input  tcf_pkg::ring_flags_t      flags0,
  input  tcf_pkg::ring_flags_t      flags1,
  input  logic [tcf_pkg::TAG_W-1:0] tag0,
  input  logic [tcf_pkg::TAG_W-1:0] tag1,
  input  logic [STAMP_BITS-1:0]     stamp0,
  input  logic [STAMP_BITS-1:0]     stamp1,
  output tcf_pkg::ring_ctl_t        ctl0,
  output tcf_pkg::ring_ctl_t        ctl1,
  output logic                      bump_arrival,
  output tcf_pkg::out_word_t        result
);
  import tcf_pkg::*;

  logic [STAMP_BITS-1:0] age0, age1;
  logic                  take0, take1;

  assign age0 = arrival - stamp0;
  assign age1 = arrival - stamp1;

  always_comb begin
    ctl0   = '0;
    ctl1   = '0;
    take0  = 1'b0;
    take1  = 1'b0;
    result = '0;
    if (cmd_valid) begin
      unique case (cmd.command)
        CMD_ENQ: begin
          if (cmd.item_class == CLS_FIRST) begin
            ctl0.push = !flags0.full;
            result.status = flags0.full ? ST_FULL : ST_OK;
          end else begin
            ctl1.push = !flags1.full;
            result.status = flags1.full ? ST_FULL : ST_OK;
          end
        end
        CMD_DEQ_NAMED: begin
          take0 = (cmd.item_class == CLS_FIRST)  && !flags0.empty;
          take1 = (cmd.item_class == CLS_SECOND) && !flags1.empty;
        end
        CMD_DEQ_OLDEST: begin
          // serve the larger age; ties and a lone first class go first
          if (!flags0.empty && !flags1.empty) begin
            take1 = (age1 > age0);
            take0 = !take1;
          end else begin
            take0 = !flags0.empty;
            take1 = flags0.empty && !flags1.empty;
          end
        end
        CMD_NOP: begin
        end
        default: begin
        end
      endcase
      if (cmd.command == CMD_DEQ_NAMED || cmd.command == CMD_DEQ_OLDEST) begin
        ctl0.pop = take0;
        ctl1.pop = take1;
        if (take0) begin
          result.out_tag = tag0;
          result.served_class = CLS_FIRST;
        end else if (take1) begin
          result.out_tag = tag1;
          result.served_class = CLS_SECOND;
        end else begin
          result.status = ST_EMPTY;
        end
      end
    end
  end

  assign bump_arrival = ctl0.push | ctl1.push;

endmodule

// File: tb/sv/two_class_fifo_oldest_first_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_class_fifo_oldest_first_tb - self-checking bench for the two-class FIFO
// Drives enqueue, named dequeue, oldest-first dequeue and no-op words and
// checks every result word against a cycle-free model of the two rings and
// their shared arrival stamp.
// ----------------------------------------------------------------------------
module two_class_fifo_oldest_first_tb;
  import tcf_pkg::*;

  localparam int DEPTH   = DEPTH_DEF;
  localparam int STAMP_W = STAMP_DEF;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } slot_t;

  typedef struct {
    in_word_t word;
    int       idle_pct;
    bit       wait_drain;
  } cmd_slot_t;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_word_t  in_data;
  logic      out_strobe;
  out_word_t out_data;

  cmd_slot_t pending_cmds[$];
  out_word_t due_words[$];
  int        errors = 0;

  // model state: one ring per class plus the shared arrival counter
  slot_t              ring_mem  [0:1][DEPTH];
  int                 ring_head [0:1] = '{0, 0};
  int                 ring_tail [0:1] = '{0, 0};
  logic [STAMP_W-1:0] arrival_now = '0;

  two_class_fifo_oldest_first #(
    .DEPTH      (DEPTH),
    .STAMP_BITS (STAMP_W)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bit ring_empty(int cls);
    return ring_head[cls] == ring_tail[cls];
  endfunction

  // Apply one command to the model and return the word it must produce
  function automatic out_word_t serve_command(in_word_t w);
    out_word_t          r;
    int                 cls;
    int                 pick;
    logic [STAMP_W-1:0] age0;
    logic [STAMP_W-1:0] age1;
    r    = '0;
    pick = -1;
    cls  = int'(w.item_class);
    case (w.command)
      CMD_ENQ: begin
        if ((ring_tail[cls] + 1) % DEPTH == ring_head[cls]) begin
          r.status = ST_FULL;
        end else begin
          ring_mem[cls][ring_tail[cls]] = '{tag: w.item_tag, stamp: arrival_now};
          ring_tail[cls] = (ring_tail[cls] + 1) % DEPTH;
          arrival_now    = arrival_now + 1'b1;
        end
      end
      CMD_DEQ_NAMED: begin
        if (!ring_empty(cls)) pick = cls;
      end
      CMD_DEQ_OLDEST: begin
        if (!ring_empty(0) && !ring_empty(1)) begin
          // age counts modulo the stamp width, so it survives a wrap
          age0 = arrival_now - ring_mem[0][ring_head[0]].stamp;
          age1 = arrival_now - ring_mem[1][ring_head[1]].stamp;
          pick = (age1 > age0) ? 1 : 0;
        end else if (!ring_empty(0)) begin
          pick = 0;
        end else if (!ring_empty(1)) begin
          pick = 1;
        end
      end
      default: ;
    endcase
    if (pick >= 0) begin
      r.out_tag      = ring_mem[pick][ring_head[pick]].tag;
      r.served_class = (pick == 1) ? CLS_SECOND : CLS_FIRST;
      ring_head[pick] = (ring_head[pick] + 1) % DEPTH;
    end else if (w.command == CMD_DEQ_NAMED || w.command == CMD_DEQ_OLDEST) begin
      r.status = ST_EMPTY;
    end
    return r;
  endfunction

  task automatic queue_cmd(logic [1:0] cmd, logic cls, logic [TAG_W-1:0] tag,
                           int idle_pct, bit wait_drain);
    cmd_slot_t s;
    s.word.command    = cmd;
    s.word.item_class = cls;
    s.word.item_tag   = tag;
    s.idle_pct        = idle_pct;
    s.wait_drain      = wait_drain;
    pending_cmds.push_back(s);
  endtask

  // Random words, leaning towards one class so rings reach full or empty
  task automatic queue_random_block(int n, int idle_pct, mix_t mix, bit drain_first);
    int         enq_pct;
    int         r;
    logic       fav;
    logic [1:0] cmd;
    logic       cls;
    enq_pct = (mix == MIX_FILL) ? 80 : (mix == MIX_DRAIN) ? 15 : 45;
    fav     = 1'($urandom_range(0, 1));
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 3) cmd = CMD_NOP;
      else if (r < 3 + enq_pct) cmd = CMD_ENQ;
      else cmd = $urandom_range(0, 1) ? CMD_DEQ_OLDEST : CMD_DEQ_NAMED;
      cls = ($urandom_range(0, 99) < 75) ? fav : ~fav;
      queue_cmd(cmd, cls, TAG_W'($urandom), idle_pct, drain_first && (i == 0));
    end
  endtask

  task automatic log_error(string msg);
    errors++;
    if (errors <= 10) $display("ERROR at %0t: %s", $time, msg);
  endtask

  // Driver: take the accepted word into the model, then offer the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      start   <= 1'b0;
      in_data <= '0;
    end else if (!(start && busy)) begin
      if (start) begin
        due_words.push_back(serve_command(in_data));
        void'(pending_cmds.pop_front());
      end
      if (pending_cmds.size() == 0) begin
        start <= 1'b0;
      end else if (pending_cmds[0].wait_drain && (start || due_words.size() != 0)) begin
        start <= 1'b0;
      end else if ($urandom_range(0, 99) < pending_cmds[0].idle_pct) begin
        start <= 1'b0;
      end else begin
        start   <= 1'b1;
        in_data <= pending_cmds[0].word;
      end
    end
  end

  // Monitor: every strobed word must match the oldest word due
  always @(posedge clk) begin : result_check
    out_word_t want;
    if (rst_n && out_strobe) begin
      if (due_words.size() == 0) begin
        log_error($sformatf("word with none due: tag %02h class %0d status %0d",
                            out_data.out_tag, out_data.served_class, out_data.status));
      end else begin
        want = due_words.pop_front();
        if (out_data.out_tag !== want.out_tag)
          log_error($sformatf("out_tag expected %02h got %02h",
                              want.out_tag, out_data.out_tag));
        if (out_data.served_class !== want.served_class)
          log_error($sformatf("served_class expected %0d got %0d",
                              want.served_class, out_data.served_class));
        if (out_data.status !== want.status)
          log_error($sformatf("status expected %0d got %0d",
                              want.status, out_data.status));
      end
    end
  end

  initial begin
    #20_000_000;
    $display("** two_class_fifo_oldest_first: FAILED **");
    $finish;
  end

  initial begin
    int   idle_phase [4] = '{0, 86, 0, 7};
    mix_t mix;
    rst_n   = 1'b0;

    // directed: empty dequeues, no-op, age order, fill to full, fallback
    queue_cmd(CMD_DEQ_NAMED,  CLS_FIRST,  8'h00, 0, 1'b0);
    queue_cmd(CMD_DEQ_OLDEST, CLS_SECOND, 8'h00, 0, 1'b0);
    queue_cmd(CMD_NOP,        CLS_SECOND, 8'hFF, 0, 1'b0);
    queue_cmd(CMD_ENQ,        CLS_SECOND, 8'hFF, 0, 1'b0);
    queue_cmd(CMD_ENQ,        CLS_FIRST,  8'h00, 0, 1'b0);
    queue_cmd(CMD_DEQ_OLDEST, CLS_FIRST,  8'h00, 0, 1'b0);
    for (int i = 0; i < DEPTH - 1; i++)
      queue_cmd(CMD_ENQ, CLS_FIRST, TAG_W'($urandom), 0, 1'b0);
    queue_cmd(CMD_DEQ_NAMED,  CLS_SECOND, 8'hAA, 0, 1'b0);
    queue_cmd(CMD_DEQ_OLDEST, CLS_SECOND, 8'h55, 0, 1'b0);

    // random phases, each opened by a pause until all results are back
    foreach (idle_phase[p]) begin
      for (int b = 0; b < 4; b++) begin
        mix = (b == 0) ? MIX_FILL : mix_t'($urandom_range(0, 2));
        queue_random_block(44, idle_phase[p], mix, b == 0);
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // drain, then allow the pipeline to settle
    wait (pending_cmds.size() == 0 && start == 1'b0);
    wait (due_words.size() == 0);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("** two_class_fifo_oldest_first: PASSED **");
    end else begin
      $display("** two_class_fifo_oldest_first: FAILED **");
    end
    $finish;
  end

endmodule
